[rtl/prr_pkg.sv]
// Shared types and constants of the polyphase rational resampler.
package prr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int MODE_W      = 2;
    localparam int IDX_W       = 11;
    localparam int L_W         = 7;
    localparam int M_W         = 8;
    localparam int FLEN_W      = 12;
    localparam int PHASE_W     = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLEN   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]             mode;
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [IDX_W-1:0]              coef_index;
        logic signed [COEF_BITS-1:0]   coef_value;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          last;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_LOAD,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                     kind;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [IDX_W-1:0]              index;
        logic signed [COEF_BITS-1:0]   value;
    } t_cmd;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

[rtl/prr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/prr_front.sv]
// Front end: accepts input transactions, classifies them and queues commands.
module prr_front #(
    parameter int MAX_COEFS = 2048
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  prr_pkg::t_in_item i_item,
    input  logic             i_hold,
    output logic             o_full,
    output logic             o_q_valid,
    output prr_pkg::t_cmd    o_q_cmd,
    input  logic             i_q_pop
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    prr_pkg::t_cmd     r_q [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_cnt;
    logic              keep;
    logic              wr_en;
    logic              rd_en;
    prr_pkg::t_cmd     cmd;

    // classify: mode 3 and out-of-range loads are taken and dropped
    always_comb begin
        cmd.sample = i_item.sample_in;
        cmd.index  = i_item.coef_index;
        cmd.value  = i_item.coef_value;
        cmd.kind   = prr_pkg::CMD_PUSH;
        keep       = 1'b0;
        unique case (i_item.mode)
            prr_pkg::MODE_PUSH: begin
                keep = 1'b1;
            end
            prr_pkg::MODE_LOAD: begin
                cmd.kind = prr_pkg::CMD_LOAD;
                keep     = (32'(i_item.coef_index) < MAX_COEFS);
            end
            prr_pkg::MODE_CLEAR: begin
                cmd.kind = prr_pkg::CMD_CLEAR;
                keep     = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full    = (r_cnt == (AW+1)'(DEPTH)) || i_hold;
    assign wr_en     = i_push && !o_full && keep;
    assign o_q_valid = (r_cnt != '0);
    assign rd_en     = i_q_pop && o_q_valid;
    assign o_q_cmd   = r_q[r_rd];

    // command queue
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= cmd;
        end
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH))
        else $error("command queue count above depth");
    a_no_write_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(DEPTH)) && !rd_en |=> r_cnt == (AW+1)'(DEPTH))
        else $error("command queue lost its contents");
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hold |-> o_full)
        else $error("input open during history clear");

endmodule

[rtl/prr_back.sv]
// Back end: configuration, coefficient and history memories, MAC engine, output register.
module prr_back #(
    parameter int MAX_COEFS  = 2048,
    parameter int MAX_PHASES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prr_pkg::t_cfg_wr   i_cfg,
    input  logic               i_q_valid,
    input  prr_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    output logic               o_init,
    output logic               o_out_valid,
    output prr_pkg::t_out_item o_out,
    input  logic               i_pop
);

    localparam int SB    = prr_pkg::SAMPLE_BITS;
    localparam int CB    = prr_pkg::COEF_BITS;
    localparam int PH    = prr_pkg::PHASE_W;
    localparam int CA    = $clog2(MAX_COEFS);
    localparam int HA    = $clog2(MAX_COEFS + 1);
    localparam int PW    = $clog2(MAX_COEFS + 2);
    localparam int DW    = $clog2(MAX_COEFS + MAX_PHASES + 1);
    localparam int CW    = $clog2(DW);
    localparam int LW    = $clog2(MAX_PHASES + 1);
    localparam int NW    = $clog2(MAX_COEFS + 1);
    localparam int ACC_W = SB + CB + $clog2(MAX_COEFS) + 1;
    localparam int SHIFT = CB - 2;
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (CB - 3);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SB - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_WRITE,
        S_PHASE,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic                    r_init;
    logic [prr_pkg::L_W-1:0]    r_interp;
    logic [prr_pkg::M_W-1:0]    r_decim;
    logic [prr_pkg::FLEN_W-1:0] r_flen;
    logic [LW-1:0]           r_l;
    logic [prr_pkg::M_W-1:0] r_m;
    logic [NW-1:0]           r_len;
    logic signed [SB-1:0]    r_sample;
    logic [PW-1:0]           r_wp;
    logic [PW-1:0]           r_taps;
    logic [PW-1:0]           r_size;
    logic [PW-1:0]           r_clr;
    logic [PH-1:0]           r_phase;
    // divider
    logic                    r_div_mod;
    logic [DW-1:0]           r_dnum;
    logic [DW-1:0]           r_dden;
    logic [DW-1:0]           r_drem;
    logic [DW-1:0]           r_dq;
    logic [CW-1:0]           r_dcnt;
    // MAC
    logic [DW-1:0]           r_ci;
    logic [PW-1:0]           r_pos;
    logic [PW-1:0]           r_k;
    logic                    r_s1_v, r_s1_use, r_s1_last;
    logic                    r_s2_v, r_s2_use, r_s2_last;
    logic signed [SB+CB-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_acc_done;
    logic                    r_out_valid;
    prr_pkg::t_out_item      r_out;

    logic [DW:0]             rem_sh;
    logic                    div_ge;
    logic [DW-1:0]           rem_nx;
    logic [DW-1:0]           q_nx;
    logic [31:0]             l32, f32;
    logic [LW-1:0]           eff_l;
    logic [prr_pkg::M_W-1:0] eff_m;
    logic [NW-1:0]           eff_len;
    logic signed [ACC_W-1:0] y_sh;
    logic signed [SB-1:0]    y_sat;
    logic [PH-1:0]           phase_nx;
    logic                    out_free;
    logic                    coef_we;
    logic                    hist_we;
    logic [HA-1:0]           hist_waddr;
    logic signed [SB-1:0]    hist_wdata;
    logic                    mac_re;
    logic signed [CB-1:0]    coef_rd;
    logic signed [SB-1:0]    hist_rd;

    // effective register values
    always_comb begin
        l32 = 32'(r_interp);
        if (l32 == 0) begin
            eff_l = LW'(1);
        end else if (l32 > MAX_PHASES) begin
            eff_l = LW'(MAX_PHASES);
        end else begin
            eff_l = LW'(l32);
        end
        eff_m = (r_decim == '0) ? prr_pkg::M_W'(1) : r_decim;
        f32 = 32'(r_flen);
        if (f32 == 0) begin
            eff_len = NW'(1);
        end else if (f32 > MAX_COEFS) begin
            eff_len = NW'(MAX_COEFS);
        end else begin
            eff_len = NW'(f32);
        end
    end

    // one restoring division step
    always_comb begin
        rem_sh = {r_drem, r_dnum[DW-1]};
        div_ge = (rem_sh >= {1'b0, r_dden});
        rem_nx = div_ge ? DW'(rem_sh - {1'b0, r_dden}) : DW'(rem_sh);
        q_nx   = {r_dq[DW-2:0], div_ge};
    end

    // rounding, shift and saturation of the finished sum
    always_comb begin
        y_sh = (r_acc + RND) >>> SHIFT;
        if (y_sh > SAT_HI) begin
            y_sat = SB'(SAT_HI);
        end else if (y_sh < SAT_LO) begin
            y_sat = SB'(SAT_LO);
        end else begin
            y_sat = SB'(y_sh);
        end
        phase_nx = r_phase + PH'(r_m);
    end

    assign out_free   = !r_out_valid || i_pop;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign coef_we    = o_q_pop && (i_q_cmd.kind == prr_pkg::CMD_LOAD);
    assign hist_we    = (r_state == S_CLR) || (r_state == S_WRITE);
    assign hist_waddr = (r_state == S_CLR) ? HA'(r_clr) : HA'(r_wp);
    assign hist_wdata = (r_state == S_CLR) ? '0 : r_sample;
    assign mac_re     = (r_state == S_MAC);

    prr_ram #(.WIDTH(CB), .DEPTH(MAX_COEFS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (CA'(i_q_cmd.index)),
        .i_wdata (i_q_cmd.value),
        .i_re    (mac_re),
        .i_raddr (CA'(r_ci)),
        .o_rdata (coef_rd)
    );

    prr_ram #(.WIDTH(SB), .DEPTH(MAX_COEFS + 1)) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (mac_re),
        .i_raddr (HA'(r_pos)),
        .o_rdata (hist_rd)
    );

    // sequencer, MAC pipeline and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init      <= 1'b1;
            r_clr       <= '0;
            r_interp    <= prr_pkg::L_W'(1);
            r_decim     <= prr_pkg::M_W'(1);
            r_flen      <= prr_pkg::FLEN_W'(64);
            r_wp        <= '0;
            r_phase     <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_acc_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg.we) begin
                unique case (i_cfg.index)
                    prr_pkg::CFG_INTERP: r_interp <= i_cfg.data[prr_pkg::L_W-1:0];
                    prr_pkg::CFG_DECIM:  r_decim  <= i_cfg.data[prr_pkg::M_W-1:0];
                    prr_pkg::CFG_FLEN:   r_flen   <= i_cfg.data;
                    default: ;
                endcase
            end

            if (r_out_valid && i_pop) begin
                r_out_valid <= 1'b0;
            end

            // MAC pipeline: memory read, product, accumulate
            r_s1_v    <= mac_re;
            r_s1_use  <= (r_ci < DW'(r_len));
            r_s1_last <= (r_k == r_taps - 1'b1);
            r_s2_v    <= r_s1_v;
            r_s2_use  <= r_s1_use;
            r_s2_last <= r_s1_last;
            r_prod    <= coef_rd * hist_rd;
            if (r_s2_v) begin
                if (r_s2_use) begin
                    r_acc <= r_acc + ACC_W'(r_prod);
                end
                if (r_s2_last) begin
                    r_acc_done <= 1'b1;
                end
            end

            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == PW'(MAX_COEFS)) begin
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        unique case (i_q_cmd.kind)
                            prr_pkg::CMD_PUSH: begin
                                r_sample  <= i_q_cmd.sample;
                                r_l       <= eff_l;
                                r_m       <= eff_m;
                                r_len     <= eff_len;
                                r_dnum    <= DW'(eff_len) + DW'(eff_l) - DW'(1);
                                r_dden    <= DW'(eff_l);
                                r_drem    <= '0;
                                r_dcnt    <= '0;
                                r_div_mod <= 1'b0;
                                r_state   <= S_DIV;
                            end
                            prr_pkg::CMD_CLEAR: begin
                                r_clr   <= '0;
                                r_wp    <= '0;
                                r_phase <= '0;
                                r_state <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    r_dnum <= {r_dnum[DW-2:0], 1'b0};
                    r_drem <= rem_nx;
                    r_dq   <= q_nx;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == CW'(DW - 1)) begin
                        if (!r_div_mod) begin
                            // tap count known; now wrap the write pointer
                            r_taps    <= PW'(q_nx);
                            r_size    <= PW'(q_nx) + 1'b1;
                            r_dnum    <= DW'(r_wp);
                            r_dden    <= DW'(PW'(q_nx) + 1'b1);
                            r_drem    <= '0;
                            r_dcnt    <= '0;
                            r_div_mod <= 1'b1;
                        end else begin
                            r_wp    <= PW'(rem_nx);
                            r_state <= S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_wp    <= (r_wp + 1'b1 == r_size) ? '0 : r_wp + 1'b1;
                    r_state <= S_PHASE;
                end
                S_PHASE: begin
                    if (r_phase < PH'(r_l)) begin
                        r_ci       <= DW'(r_phase);
                        r_pos      <= (r_wp == '0) ? r_size - 1'b1 : r_wp - 1'b1;
                        r_k        <= '0;
                        r_acc      <= '0;
                        r_acc_done <= 1'b0;
                        r_state    <= S_MAC;
                    end else begin
                        r_phase <= r_phase - PH'(r_l);
                        r_state <= S_IDLE;
                    end
                end
                S_MAC: begin
                    r_ci  <= r_ci + DW'(r_l);
                    r_pos <= (r_pos == '0) ? r_size - 1'b1 : r_pos - 1'b1;
                    r_k   <= r_k + 1'b1;
                    if (r_k == r_taps - 1'b1) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_acc_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.sample_out <= y_sat;
                        r_out.last       <= (phase_nx >= PH'(r_l));
                        r_out_valid      <= 1'b1;
                        r_phase          <= phase_nx;
                        r_state          <= S_PHASE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_init      = r_init;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> r_phase < PH'(MAX_PHASES + 256))
        else $error("phase accumulator out of range");
    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (r_pos < r_size) && (r_taps != '0))
        else $error("history read outside ring");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_pop |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");
    a_pop_idle_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> !r_init && !r_s2_v)
        else $error("command taken while engine busy");

endmodule

[rtl/polyphase_rational_resampler.sv]
// Rational L/M polyphase resampler top level.
// Each pushed sample runs two restoring divisions, DW = clog2(MAX_COEFS+MAX_PHASES+1) bits
// wide, on one shared divider for the tap count and the ring wrap; then, per output, it does
// T = ceil(filter_length/L) multiply-accumulates, one per cycle through the coefficient and
// history memory ports; a sample makes 0 to L outputs. A coefficient load is written from
// the command queue while the engine is idle. A clear command, and reset, sweep all MAX_COEFS+1
// history entries (2049 by default) one entry a cycle; the input shows full during the sweep
// after reset. A four-entry command queue lets inputs be taken while the engine runs.
module polyphase_rational_resampler #(
    parameter int MAX_COEFS  = 2048,
    parameter int MAX_PHASES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    output logic                               o_full,
    input  prr_pkg::t_in_item                  i_in,
    output logic                               o_empty,
    input  logic                               i_pop,
    output prr_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [prr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic             q_valid;
    logic             q_pop;
    prr_pkg::t_cmd    q_cmd;
    logic             init;
    logic             out_valid;
    prr_pkg::t_cfg_wr cfg;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    prr_front #(.MAX_COEFS(MAX_COEFS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_push),
        .i_item    (i_in),
        .i_hold    (init),
        .o_full    (o_full),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    prr_back #(.MAX_COEFS(MAX_COEFS), .MAX_PHASES(MAX_PHASES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_init      (init),
        .o_out_valid (out_valid),
        .o_out       (o_out),
        .i_pop       (i_pop)
    );

    assign o_empty = !out_valid;

endmodule

[sim/tb_polyphase_rational_resampler.sv]
// Self-checking testbench of the polyphase rational resampler.
module tb_polyphase_rational_resampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [prr_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int NUM_COEFS = 2048;
    localparam int NUM_PHASES = 64;
    // covers a full command queue of history sweeps plus the one in progress
    localparam int SETTLE_CYCLES = 10500;

    logic i_clk;
    logic i_rst_n;
    logic i_push;
    logic o_full;
    prr_pkg::t_in_item i_in;
    logic o_empty;
    logic i_pop;
    prr_pkg::t_out_item o_out;
    logic i_cfg_we;
    logic [prr_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [prr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    polyphase_rational_resampler DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full), .i_in(i_in),
        .o_empty(o_empty), .i_pop(i_pop), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // predictor state
    logic signed [prr_pkg::COEF_BITS-1:0]   coef_mem [NUM_COEFS];
    logic signed [prr_pkg::SAMPLE_BITS-1:0] hist_mem [NUM_COEFS+1];
    int unsigned hist_wr;
    int unsigned phase;
    logic [prr_pkg::L_W-1:0]    l_reg;
    logic [prr_pkg::M_W-1:0]    m_reg;
    logic [prr_pkg::FLEN_W-1:0] len_reg;
    bit coef_planned [NUM_COEFS];

    prr_pkg::t_in_item  pending_items[$];
    prr_pkg::t_out_item expected_out[$];
    int mismatches = 0;
    int outputs_seen = 0;
    int items_sent = 0;
    int pushes_sent = 0;
    bit idle_free = 0;
    bit in_taken = 0;
    bit pop_taken = 0;
    int in_gap = 0;
    int pop_gap = 0;

    // one accepted transaction through the resampler
    task automatic resample_step(input prr_pkg::t_in_item it);
        int unsigned l, m, len, taps, size, ci, pos;
        longint acc, y;
        prr_pkg::t_out_item r;
        int produced;
        produced = 0;
        if (it.mode == prr_pkg::MODE_LOAD) begin
            coef_mem[it.coef_index] = it.coef_value;
        end else if (it.mode == prr_pkg::MODE_CLEAR) begin
            foreach (hist_mem[k]) hist_mem[k] = '0;
            hist_wr = 0;
            phase = 0;
        end else if (it.mode == prr_pkg::MODE_PUSH) begin
            l = (l_reg == 0) ? 1 : l_reg;
            if (l > NUM_PHASES) l = NUM_PHASES;
            m = (m_reg == 0) ? 1 : m_reg;
            len = (len_reg == 0) ? 1 : len_reg;
            if (len > NUM_COEFS) len = NUM_COEFS;
            taps = (len + l - 1) / l;
            size = taps + 1;
            hist_wr = hist_wr % size;
            hist_mem[hist_wr] = it.sample_in;
            hist_wr = (hist_wr + 1) % size;
            while (phase < l) begin
                acc = 0;
                for (int unsigned i = 0; i < taps; i++) begin
                    ci = phase + i * l;
                    pos = (hist_wr + size - 1 - i) % size;
                    if (ci < len) acc += longint'(coef_mem[ci]) * longint'(hist_mem[pos]);
                end
                acc += longint'(1) << (prr_pkg::COEF_BITS - 3);
                y = acc >>> (prr_pkg::COEF_BITS - 2);
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
                r.sample_out = y[prr_pkg::SAMPLE_BITS-1:0];
                r.last = 1'b0;
                expected_out.push_back(r);
                produced++;
                phase = (phase + m) & 9'h1FF;
            end
            phase = (phase - l) & 9'h1FF;
            if (produced > 0) expected_out[expected_out.size()-1].last = 1'b1;
        end
    endtask

    // sample accepted transactions and configuration writes
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_push && !o_full;
        pop_taken <= i_rst_n && i_pop && !o_empty;
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_index)
                prr_pkg::CFG_INTERP: l_reg <= i_cfg_data[prr_pkg::L_W-1:0];
                prr_pkg::CFG_DECIM:  m_reg <= i_cfg_data[prr_pkg::M_W-1:0];
                prr_pkg::CFG_FLEN:   len_reg <= i_cfg_data[prr_pkg::FLEN_W-1:0];
                default: ;
            endcase
        end
        if (i_rst_n && i_push && !o_full) resample_step(i_in);
        // result check against the oldest expectation
        if (i_rst_n && i_pop && !o_empty) begin
            outputs_seen++;
            if (expected_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output %0d last %0b", o_out.sample_out, o_out.last);
            end else begin
                if (o_out !== expected_out[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("output %0d: expected %0d last %0b, got %0d last %0b",
                                 outputs_seen, expected_out[0].sample_out,
                                 expected_out[0].last, o_out.sample_out, o_out.last);
                end
                void'(expected_out.pop_front());
            end
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_push && !in_taken)) begin
            if (in_gap > 0) begin
                i_push <= 1'b0;
                in_gap <= in_gap - 1;
            end else if (pending_items.size() > 0) begin
                i_in <= pending_items.pop_front();
                i_push <= 1'b1;
                in_gap <= idle_free ? 0 : $urandom_range(0, 14);
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // result receiver with random stalls
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_pop && !pop_taken)) begin
            if (pop_gap > 0) begin
                i_pop <= 1'b0;
                pop_gap <= pop_gap - 1;
            end else begin
                i_pop <= 1'b1;
                pop_gap <= idle_free ? 0 : $urandom_range(0, 14);
            end
        end
    end

    task automatic queue_item(input logic [prr_pkg::MODE_W-1:0] mode, input logic [15:0] s,
                              input logic [prr_pkg::IDX_W-1:0] idx, input logic [15:0] v);
        prr_pkg::t_in_item it;
        it.mode = mode;
        it.sample_in = s;
        it.coef_index = idx;
        it.coef_value = v;
        if (mode == prr_pkg::MODE_LOAD) coef_planned[idx] = 1;
        if (mode == prr_pkg::MODE_PUSH) pushes_sent++;
        items_sent++;
        pending_items.push_back(it);
    endtask

    // load every coefficient below n that has not been queued for loading yet
    task automatic fill_coefs(input int n);
        for (int k = 0; k < n; k++)
            if (!coef_planned[k])
                queue_item(prr_pkg::MODE_LOAD, 16'($urandom), prr_pkg::IDX_W'(k),
                           16'($urandom));
    endtask

    task automatic random_items(input int n);
        int r;
        logic [15:0] s;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            s = 16'($urandom);
            if ($urandom_range(0, 9) == 0) s = ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            if (r < 80)
                queue_item(prr_pkg::MODE_PUSH, s, prr_pkg::IDX_W'($urandom), 16'($urandom));
            else if (r < 90)
                queue_item(prr_pkg::MODE_LOAD, 16'($urandom), prr_pkg::IDX_W'($urandom),
                           16'($urandom));
            else if (r < 95)
                queue_item(prr_pkg::MODE_CLEAR, 16'($urandom), prr_pkg::IDX_W'($urandom),
                           16'($urandom));
            else
                queue_item(MODE_NONE, 16'($urandom), prr_pkg::IDX_W'($urandom),
                           16'($urandom));
        end
    endtask

    // wait for all stimulus and results, then let any sweep finish
    task automatic drain();
        while (pending_items.size() > 0 || i_push || expected_out.size() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [prr_pkg::CFG_IDX_W-1:0] idx, input int data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data[prr_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_ratio(input int l, input int m, input int n);
        write_reg(prr_pkg::CFG_INTERP, l);
        @(negedge i_clk);
        write_reg(prr_pkg::CFG_DECIM, m);
        @(negedge i_clk);
        write_reg(prr_pkg::CFG_FLEN, n);
        @(negedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        l_reg = 1;
        m_reg = 1;
        len_reg = 64;
        hist_wr = 0;
        phase = 0;
        foreach (hist_mem[k]) hist_mem[k] = '0;
        foreach (coef_mem[k]) coef_mem[k] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-scale taps and samples, saturation, clear, unused mode
        queue_item(prr_pkg::MODE_LOAD, 16'h0000, 11'd0, 16'h7FFF);
        queue_item(prr_pkg::MODE_LOAD, 16'hFFFF, 11'd63, 16'h8000);
        queue_item(prr_pkg::MODE_LOAD, 16'h1234, 11'd2047, 16'h7FFF);
        for (int k = 1; k < 63; k++)
            queue_item(prr_pkg::MODE_LOAD, 16'h0, prr_pkg::IDX_W'(k), 16'h7FFF);
        queue_item(prr_pkg::MODE_PUSH, 16'h7FFF, 11'd0, 16'h0);
        queue_item(prr_pkg::MODE_PUSH, 16'h7FFF, 11'h7FF, 16'hFFFF);
        queue_item(prr_pkg::MODE_PUSH, 16'h8000, 11'd0, 16'h0);
        queue_item(prr_pkg::MODE_PUSH, 16'h0000, 11'd0, 16'h0);
        queue_item(prr_pkg::MODE_PUSH, 16'hFFFF, 11'd0, 16'h0);
        queue_item(prr_pkg::MODE_PUSH, 16'h0001, 11'd0, 16'h0);
        queue_item(MODE_NONE, 16'h7FFF, 11'h7FF, 16'h7FFF);
        queue_item(prr_pkg::MODE_CLEAR, 16'hFFFF, 11'h7FF, 16'hFFFF);
        queue_item(prr_pkg::MODE_PUSH, 16'h8000, 11'd0, 16'h0);
        queue_item(prr_pkg::MODE_LOAD, 16'h0, 11'd0, 16'h4000);
        queue_item(prr_pkg::MODE_PUSH, 16'h4000, 11'd0, 16'h0);
        queue_item(prr_pkg::MODE_PUSH, 16'hC000, 11'd0, 16'h0);
        fill_coefs(64);
        random_items(45);
        drain();

        // three branches, step two
        set_ratio(3, 2, 40);
        idle_free = 1;
        random_items(40);
        drain();
        idle_free = 0;

        // maximum branches, unit step: up to 64 outputs per sample
        set_ratio(64, 1, 128);
        fill_coefs(128);
        random_items(20);
        drain();

        // zero registers act as one
        set_ratio(0, 0, 0);
        random_items(30);
        drain();

        set_ratio(5, 7, 128);
        random_items(40);
        drain();

        // branch count above the maximum clamps to the maximum
        set_ratio(127, 3, 128);
        random_items(30);
        drain();

        // longest tap count of this run, tied with the first section
        set_ratio(2, 3, 128);
        random_items(30);
        drain();

        $display("tb: %0d items (%0d samples) over 7 ratio settings, %0d outputs checked",
                 items_sent, pushes_sent, outputs_seen);
        $display("tb: %0d mismatches, %0d expected outputs never seen",
                 mismatches, expected_out.size());
        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("timeout with %0d outputs outstanding", expected_out.size());
        $display("tb: failure");
        $finish;
    end

endmodule
